/* hdl/source_tokenizer_assert.svh */
// assertion macros used by the tokenizer queue
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// condition implies consequence in the same cycle
`define STOK_ASSERT_NOW(lbl, ck, rs, cond, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |-> (cons)) \
    else $error("tokenizer check failed");

// condition implies consequence in the following cycle
`define STOK_ASSERT_NEXT(lbl, ck, rs, cond, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

/* hdl/stok_pkg.sv */
// shared types, constants and tables of the source tokenizer
package stok_pkg;

  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;
  localparam int LENGTH_BITS = 16;
  localparam int OFFSET_BITS = 24;
  localparam int MAX_TOKENS  = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [3:0] {
    MD_IDLE    = 4'd0,
    MD_COMMENT = 4'd1,
    MD_STRING  = 4'd2,
    MD_OP      = 4'd3,
    MD_IDENT   = 4'd4,
    MD_NUM0    = 4'd5,
    MD_NUM     = 4'd6,
    MD_NUMDOT  = 4'd7,
    MD_FRAC    = 4'd8
  } mode_t;

  localparam logic [5:0] K_NONE     = 6'd0;
  localparam logic [5:0] K_DOT      = 6'd9;
  localparam logic [5:0] K_STAR     = 6'd14;
  localparam logic [5:0] K_DBLSTAR  = 6'd15;
  localparam logic [5:0] K_SLASH    = 6'd16;
  localparam logic [5:0] K_DBLSLASH = 6'd17;
  localparam logic [5:0] K_EQUAL    = 6'd18;
  localparam logic [5:0] K_DBLEQUAL = 6'd19;
  localparam logic [5:0] K_ARROW    = 6'd20;
  localparam logic [5:0] K_GREATER  = 6'd21;
  localparam logic [5:0] K_GTEQUAL  = 6'd22;
  localparam logic [5:0] K_LESS     = 6'd23;
  localparam logic [5:0] K_LSEQUAL  = 6'd24;
  localparam logic [5:0] K_LSGT     = 6'd25;
  localparam logic [5:0] K_STRING   = 6'd26;
  localparam logic [5:0] K_KW0      = 6'd27;
  localparam logic [5:0] K_ID       = 6'd52;
  localparam logic [5:0] K_INT      = 6'd53;
  localparam logic [5:0] K_FLOAT    = 6'd54;
  localparam logic [5:0] K_END      = 6'd55;
  localparam logic [5:0] K_ERROR    = 6'd56;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNTERM   = 2'd1;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd2;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // keywords, first letter in the low byte
  localparam logic [47:0] KW_TEXT [25] = '{
    48'("dna"), 48'("tsnoc"), 48'("esle"), 48'("23f"), 48'("46f"),
    48'("eslaf"), 48'("rof"), 48'("cnuf"), 48'("8i"), 48'("61i"),
    48'("23i"), 48'("46i"), 48'("fi"), 48'("ton"), 48'("llun"),
    48'("ro"), 48'("nruter"), 48'("eurt"), 48'("8u"), 48'("61u"),
    48'("23u"), 48'("46u"), 48'("rav"), 48'("elihw"), 48'("rox")
  };

  typedef struct packed {
    logic [5:0]             kind;
    logic [1:0]             err;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [LENGTH_BITS-1:0] len;
    logic [OFFSET_BITS-1:0] off;
  } tok_t;

  // tokens caused by one source byte
  typedef struct packed {
    tok_t [MAX_TOKENS-1:0] tk;
    logic [2:0]            cnt;
  } bundle_t;

endpackage

/* hdl/stok_scan.sv */
// front end: classifies each source byte and builds its token bundle
module stok_scan
  import stok_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    ch,
  input  logic          last,
  output bundle_t       bundle
);

  typedef struct packed {
    mode_t                  mode;
    logic [5:0]             pend;
    logic [47:0]            kw;
    logic [1:0]             radix;
    logic [LENGTH_BITS-1:0] rlen;
    logic [OFFSET_BITS-1:0] roff;
    logic [LINE_BITS-1:0]   rline;
    logic [COLUMN_BITS-1:0] rcol;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [OFFSET_BITS-1:0] off;
  } st_t;

  localparam st_t ST_RESET = '{
    mode: MD_IDLE, pend: K_NONE, kw: '0, radix: RADIX_DEC, rlen: '0, roff: '0,
    rline: LINE_BITS'(1), rcol: COLUMN_BITS'(1), line: LINE_BITS'(1),
    col: COLUMN_BITS'(1), off: '0};

  st_t st, st_next;

  function automatic st_t eat(input st_t si);
    st_t s;
    s = si;
    if (s.col != '1) s.col = s.col + 1'b1;
    if (s.off != '1) s.off = s.off + 1'b1;
    return s;
  endfunction

  function automatic st_t grow(input st_t si);
    st_t s;
    s = eat(si);
    if (s.rlen != '1) s.rlen = s.rlen + 1'b1;
    return s;
  endfunction

  function automatic st_t start_run(input st_t si);
    st_t s;
    s = si;
    s.rline = s.line;
    s.rcol  = s.col;
    s.roff  = s.off;
    s.rlen  = '0;
    s.kw    = '0;
    return grow(s);
  endfunction

  function automatic tok_t run_tok(input st_t s, input logic [5:0] k, input logic [1:0] e);
    tok_t t;
    t.kind = k; t.err = e; t.line = s.rline; t.col = s.rcol;
    t.len = s.rlen; t.off = s.roff;
    return t;
  endfunction

  function automatic bundle_t push(input bundle_t bi, input tok_t t, input logic v);
    bundle_t b;
    b = bi;
    if (v && b.cnt < 3'(MAX_TOKENS)) begin
      b.tk[b.cnt[1:0]] = t;
      b.cnt = b.cnt + 3'd1;
    end
    return b;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic radix_digit(input logic [1:0] r, input logic [7:0] b);
    logic d;
    unique case (r)
      RADIX_BIN: d = (b == "0") || (b == "1");
      RADIX_OCT: d = b >= "0" && b <= "7";
      RADIX_HEX: d = is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
      default:   d = is_digit(b);
    endcase
    return d;
  endfunction

  function automatic logic [5:0] ident_kind(input st_t s);
    logic [5:0] k;
    k = K_ID;
    if (s.rlen <= LENGTH_BITS'(6)) begin
      for (int i = 24; i >= 0; i--) begin
        if (s.kw == KW_TEXT[i]) k = K_KW0 + 6'(i);
      end
    end
    return k;
  endfunction

  // single-byte punctuation, code equals the token kind
  function automatic logic [4:0] punct(input logic [7:0] b);
    logic [4:0] p;
    unique case (b)
      "(": p = 5'd0;   ")": p = 5'd1;   "[": p = 5'd2;   "]": p = 5'd3;
      "{": p = 5'd4;   "}": p = 5'd5;   ":": p = 5'd6;   ";": p = 5'd7;
      ",": p = 5'd8;   ".": p = 5'd9;   "+": p = 5'd10;  "-": p = 5'd11;
      "%": p = 5'd12;  "$": p = 5'd13;
      default: p = 5'd31;
    endcase
    return p;
  endfunction

  function automatic logic [5:0] op_first(input logic [7:0] b);
    logic [5:0] k;
    unique case (b)
      "*": k = K_STAR;
      "/": k = K_SLASH;
      "=": k = K_EQUAL;
      ">": k = K_GREATER;
      "<": k = K_LESS;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_second(input logic [5:0] f, input logic [7:0] b);
    logic [5:0] k;
    k = K_NONE;
    if (f == K_STAR && b == "*") k = K_DBLSTAR;
    if (f == K_SLASH && b == "/") k = K_DBLSLASH;
    if (f == K_EQUAL && b == "=") k = K_DBLEQUAL;
    if (f == K_EQUAL && b == ">") k = K_ARROW;
    if (f == K_GREATER && b == "=") k = K_GTEQUAL;
    if (f == K_LESS && b == "=") k = K_LSEQUAL;
    if (f == K_LESS && b == ">") k = K_LSGT;
    return k;
  endfunction

  // byte seen between tokens, at most one token
  function automatic st_t idle_f(input st_t si, input logic [7:0] b,
                                 output tok_t t, output logic v);
    st_t s;
    logic [4:0] p;
    s = si;
    v = 1'b0;
    t = '0;
    p = punct(b);
    if (b == CH_SPACE || b == CH_TAB) begin
      s = eat(s);
    end else if (b == CH_CR) begin
      if (s.off != '1) s.off = s.off + 1'b1;
    end else if (b == CH_LF) begin
      if (s.off != '1) s.off = s.off + 1'b1;
      if (s.line != '1) s.line = s.line + 1'b1;
      s.col = COLUMN_BITS'(1);
    end else if (b == CH_HASH) begin
      s = eat(s);
      s.mode = MD_COMMENT;
    end else if (p != 5'd31) begin
      s = start_run(s);
      t = run_tok(s, {1'b0, p}, ERR_NONE);
      v = 1'b1;
    end else begin
      s.pend = op_first(b);
      s = start_run(s);
      if (s.pend != K_NONE) begin
        s.mode = MD_OP;
      end else if (b == CH_QUOTE) begin
        s.mode = MD_STRING;
      end else if (is_alpha(b) || b == CH_UNDER) begin
        s.kw = {40'd0, b};
        s.mode = MD_IDENT;
      end else if (is_digit(b)) begin
        s.radix = RADIX_DEC;
        s.mode = (b == "0") ? MD_NUM0 : MD_NUM;
      end else begin
        t = run_tok(s, K_ERROR, ERR_BAD_CHAR);
        v = 1'b1;
      end
    end
    return s;
  endfunction

  always_comb begin
    st_t     s;
    bundle_t bd;
    tok_t    t;
    logic    v;
    logic [5:0] k;
    mode_t   m;
    s  = st;
    bd = '0;
    t  = '0;
    v  = 1'b0;
    k  = K_NONE;
    m  = st.mode;
    if (ch != CH_NUL) begin
      if (m == MD_NUM0) begin
        if (ch == "b" || ch == "o" || ch == "x") begin
          s.radix = (ch == "b") ? RADIX_BIN : (ch == "o") ? RADIX_OCT : RADIX_HEX;
          s = grow(s);
          s.mode = MD_NUM;
        end else begin
          m = MD_NUM;
          s.mode = MD_NUM;
        end
      end
      unique case (m)
        MD_NUM0: ;
        MD_COMMENT: begin
          if (ch == CH_LF) begin
            s.mode = MD_IDLE;
            s = idle_f(s, ch, t, v);
            bd = push(bd, t, v);
          end else s = eat(s);
        end
        MD_STRING: begin
          if (ch == CH_QUOTE) begin
            s = grow(s);
            bd = push(bd, run_tok(s, K_STRING, ERR_NONE), 1'b1);
            s.mode = MD_IDLE;
          end else if (ch == CH_LF) begin
            bd = push(bd, run_tok(s, K_ERROR, ERR_UNTERM), 1'b1);
            s.mode = MD_IDLE;
            s = idle_f(s, ch, t, v);
            bd = push(bd, t, v);
          end else s = grow(s);
        end
        MD_OP: begin
          k = op_second(s.pend, ch);
          if (k != K_NONE) begin
            s = grow(s);
            bd = push(bd, run_tok(s, k, ERR_NONE), 1'b1);
            s.mode = MD_IDLE;
          end else begin
            bd = push(bd, run_tok(s, s.pend, ERR_NONE), 1'b1);
            s.mode = MD_IDLE;
            s = idle_f(s, ch, t, v);
            bd = push(bd, t, v);
          end
        end
        MD_IDENT: begin
          if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER) begin
            if (s.rlen < LENGTH_BITS'(6)) s.kw[{s.rlen[2:0], 3'b000} +: 8] = ch;
            s = grow(s);
          end else begin
            bd = push(bd, run_tok(s, ident_kind(s), ERR_NONE), 1'b1);
            s.mode = MD_IDLE;
            s = idle_f(s, ch, t, v);
            bd = push(bd, t, v);
          end
        end
        MD_NUM: begin
          if (radix_digit(s.radix, ch)) s = grow(s);
          else if (ch == CH_DOT) s.mode = MD_NUMDOT;
          else begin
            bd = push(bd, run_tok(s, K_INT, ERR_NONE), 1'b1);
            s.mode = MD_IDLE;
            s = idle_f(s, ch, t, v);
            bd = push(bd, t, v);
          end
        end
        MD_NUMDOT: begin
          if (radix_digit(s.radix, ch)) begin
            s = grow(grow(s));
            s.mode = MD_FRAC;
          end else begin
            bd = push(bd, run_tok(s, K_INT, ERR_NONE), 1'b1);
            s.mode = MD_IDLE;
            s = idle_f(s, CH_DOT, t, v);
            bd = push(bd, t, v);
            s = idle_f(s, ch, t, v);
            bd = push(bd, t, v);
          end
        end
        MD_FRAC: begin
          if (radix_digit(s.radix, ch)) s = grow(s);
          else begin
            bd = push(bd, run_tok(s, K_FLOAT, ERR_NONE), 1'b1);
            s.mode = MD_IDLE;
            s = idle_f(s, ch, t, v);
            bd = push(bd, t, v);
          end
        end
        default: begin
          s.mode = MD_IDLE;
          s = idle_f(s, ch, t, v);
          bd = push(bd, t, v);
        end
      endcase
    end
    // end of source: flush the open token, then the end token
    if (ch == CH_NUL || last) begin
      unique case (s.mode)
        MD_STRING: bd = push(bd, run_tok(s, K_ERROR, ERR_UNTERM), 1'b1);
        MD_OP:     bd = push(bd, run_tok(s, s.pend, ERR_NONE), 1'b1);
        MD_IDENT:  bd = push(bd, run_tok(s, ident_kind(s), ERR_NONE), 1'b1);
        MD_NUM0, MD_NUM: bd = push(bd, run_tok(s, K_INT, ERR_NONE), 1'b1);
        MD_NUMDOT: begin
          bd = push(bd, run_tok(s, K_INT, ERR_NONE), 1'b1);
          s.mode = MD_IDLE;
          s = idle_f(s, CH_DOT, t, v);
          bd = push(bd, t, v);
        end
        MD_FRAC:   bd = push(bd, run_tok(s, K_FLOAT, ERR_NONE), 1'b1);
        default: ;
      endcase
      t.kind = K_END; t.err = ERR_NONE; t.line = s.line; t.col = s.col;
      t.len = LENGTH_BITS'(1); t.off = s.off;
      bd = push(bd, t, 1'b1);
      s = ST_RESET;
    end
    st_next = s;
    bundle  = bd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

/* hdl/stok_queue.sv */
// bundle queue between the scanner and the token emitter
module stok_queue
  import stok_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t wr_data,
  input  logic    pop,
  output bundle_t rd_data,
  output logic    full,
  output logic    empty
);

  `include "source_tokenizer_assert.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `STOK_ASSERT_NOW(a_no_overflow, clk, rst, push, !full)
  `STOK_ASSERT_NOW(a_no_underflow, clk, rst, pop, !empty)
  `STOK_ASSERT_NOW(a_no_empty_bundle, clk, rst, push, wr_data.cnt != 3'd0)
  `STOK_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

/* hdl/stok_emit.sv */
// back end: splits bundles into single tokens on a registered output
module stok_emit
  import stok_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  bundle_t head,
  input  logic    head_valid,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output tok_t    out_tok,
  output logic    out_last
);

  bundle_t    cur;
  logic       have;
  logic [1:0] idx;
  logic       load, final_tok;

  assign final_tok = ({1'b0, idx} + 3'd1) == cur.cnt;
  assign load      = have && (!out_valid || out_ready);
  assign pop       = head_valid && (!have || (load && final_tok));

  always_ff @(posedge clk) begin
    if (rst) begin
      have      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (pop) begin
        have <= 1'b1;
        idx  <= '0;
      end else if (load) begin
        if (final_tok) have <= 1'b0;
        else idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (load) begin
      out_tok  <= cur.tk[idx];
      out_last <= final_tok;
    end
  end

endmodule

/* hdl/source_tokenizer.sv */
// top level of the streaming source tokenizer
//
//  channel  | dir | data
//  s_*      | in  | tdata[7:0] source byte, tlast final byte of source
//  m_*      | out | tdata token fields, tlast last token of one source byte
//
// one source byte is taken per cycle while the bundle queue has room
// the scanner works out every token of a byte in the cycle it is accepted
// tokens leave one per cycle while m_tready is high, so the tokens of one byte leave one after another
// a token passes the queue slot, the emitter's bundle register and the output register before it appears
// rst clears scanner state, queue pointers and the output valid
// m_tready low backs up the queue, then s_tready drops once the queue is full
module source_tokenizer
  import stok_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // ch[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // token_kind[5:0], error_kind[7:6], start_line[23:8], start_column[39:24],
  // token_length[55:40], start_offset[79:56]
  output logic [79:0] m_tdata,
  output logic        m_tlast    // run_end
);

  logic    accept;
  bundle_t bundle, head;
  logic    q_full, q_empty, q_pop, q_push;
  tok_t    tok;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  // a byte that only moves counters makes no queue entry
  assign q_push   = accept && (bundle.cnt != 3'd0);

  stok_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (s_tdata),
    .last   (s_tlast),
    .bundle (bundle)
  );

  stok_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (bundle),
    .pop     (q_pop),
    .rd_data (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  stok_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_tok    (tok),
    .out_last   (m_tlast)
  );

  // fields packed from the lowest bit up
  assign m_tdata = {tok.off, tok.len, tok.col, tok.line, tok.err, tok.kind};

endmodule

/* bench/source_tokenizer_checker.sv */
// token predictor and scoreboard for the source tokenizer
module source_tokenizer_checker
  import stok_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned LINE_MAX = (64'd1 << LINE_BITS) - 1;
  localparam longint unsigned COL_MAX  = (64'd1 << COLUMN_BITS) - 1;
  localparam longint unsigned LEN_MAX  = (64'd1 << LENGTH_BITS) - 1;
  localparam longint unsigned OFF_MAX  = (64'd1 << OFFSET_BITS) - 1;

  localparam logic [7:0] PUNCT [14] = '{"(", ")", "[", "]", "{", "}", ":", ";", ",",
                                       ".", "+", "-", "%", "$"};

  // {run_end, token fields}
  logic [80:0] token_queue [$];
  logic [80:0] step_tokens [$];

  mode_t           mode;
  logic [5:0]      pending;
  logic [47:0]     kw_window;
  logic [1:0]      radix;
  longint unsigned run_len, run_off, run_line, run_col;
  longint unsigned line_no, col_no, offs;

  function automatic longint unsigned sat(longint unsigned v, longint unsigned top);
    return (v >= top) ? top : v + 1;
  endfunction

  task automatic clear_state();
    mode = MD_IDLE; pending = K_NONE; kw_window = '0; radix = RADIX_DEC;
    run_len = 0; run_off = 0; run_line = 1; run_col = 1;
    line_no = 1; col_no = 1; offs = 0;
  endtask

  task automatic emit(logic [5:0] kind, logic [1:0] err, longint unsigned ln,
                      longint unsigned col, longint unsigned len, longint unsigned off);
    step_tokens.push_back({1'b0, off[OFFSET_BITS-1:0], len[LENGTH_BITS-1:0],
                           col[COLUMN_BITS-1:0], ln[LINE_BITS-1:0], err, kind});
  endtask

  task automatic emit_run(logic [5:0] kind, logic [1:0] err);
    emit(kind, err, run_line, run_col, run_len, run_off);
  endtask

  task automatic eat();
    col_no = sat(col_no, COL_MAX);
    offs = sat(offs, OFF_MAX);
  endtask

  task automatic grow();
    eat();
    run_len = sat(run_len, LEN_MAX);
  endtask

  task automatic open_run();
    run_line = line_no; run_col = col_no; run_off = offs;
    run_len = 0; kw_window = '0;
    grow();
  endtask

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit radix_digit(logic [7:0] b);
    case (radix)
      RADIX_BIN: return b == "0" || b == "1";
      RADIX_OCT: return b >= "0" && b <= "7";
      RADIX_HEX: return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
      default:   return is_digit(b);
    endcase
  endfunction

  task automatic emit_ident();
    logic [5:0] kind;
    kind = K_ID;
    if (run_len <= 6)
      for (int i = 0; i < 25; i++)
        if (kw_window == KW_TEXT[i]) kind = K_KW0 + 6'(i);
    emit_run(kind, ERR_NONE);
  endtask

  // byte seen between tokens
  task automatic scan_idle(logic [7:0] b);
    if (b == CH_SPACE || b == CH_TAB) begin
      eat();
      return;
    end
    if (b == CH_CR) begin
      offs = sat(offs, OFF_MAX);
      return;
    end
    if (b == CH_LF) begin
      offs = sat(offs, OFF_MAX);
      line_no = sat(line_no, LINE_MAX);
      col_no = 1;
      return;
    end
    if (b == CH_HASH) begin
      eat();
      mode = MD_COMMENT;
      return;
    end
    for (int i = 0; i < 14; i++)
      if (PUNCT[i] == b) begin
        open_run();
        emit_run(6'(i), ERR_NONE);
        return;
      end
    case (b)
      "*":     pending = K_STAR;
      "/":     pending = K_SLASH;
      "=":     pending = K_EQUAL;
      ">":     pending = K_GREATER;
      "<":     pending = K_LESS;
      default: pending = K_NONE;
    endcase
    open_run();
    if (pending != K_NONE) mode = MD_OP;
    else if (b == CH_QUOTE) mode = MD_STRING;
    else if (is_alpha(b) || b == CH_UNDER) begin
      kw_window = 48'(b);
      mode = MD_IDENT;
    end else if (is_digit(b)) begin
      radix = RADIX_DEC;
      mode = (b == "0") ? MD_NUM0 : MD_NUM;
    end else emit_run(K_ERROR, ERR_BAD_CHAR);
  endtask

  function automatic logic [5:0] pair_kind(logic [5:0] first, logic [7:0] b);
    if (first == K_STAR && b == "*") return K_DBLSTAR;
    if (first == K_SLASH && b == "/") return K_DBLSLASH;
    if (first == K_EQUAL && b == "=") return K_DBLEQUAL;
    if (first == K_EQUAL && b == ">") return K_ARROW;
    if (first == K_GREATER && b == "=") return K_GTEQUAL;
    if (first == K_LESS && b == "=") return K_LSEQUAL;
    if (first == K_LESS && b == ">") return K_LSGT;
    return K_NONE;
  endfunction

  task automatic close_redo(logic [5:0] kind, logic [7:0] b);
    emit_run(kind, ERR_NONE);
    mode = MD_IDLE;
    scan_idle(b);
  endtask

  task automatic scan_byte(logic [7:0] b);
    logic [5:0] k;
    case (mode)
      MD_COMMENT: begin
        if (b == CH_LF) begin
          mode = MD_IDLE;
          scan_idle(b);
        end else eat();
      end
      MD_STRING: begin
        if (b == CH_QUOTE) begin
          grow();
          emit_run(K_STRING, ERR_NONE);
          mode = MD_IDLE;
        end else if (b == CH_LF) begin
          emit_run(K_ERROR, ERR_UNTERM);
          mode = MD_IDLE;
          scan_idle(b);
        end else grow();
      end
      MD_OP: begin
        k = pair_kind(pending, b);
        if (k != K_NONE) begin
          grow();
          emit_run(k, ERR_NONE);
          mode = MD_IDLE;
        end else close_redo(pending, b);
      end
      MD_IDENT: begin
        if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
          if (run_len < 6) kw_window |= 48'(b) << (8 * run_len);
          grow();
        end else begin
          emit_ident();
          mode = MD_IDLE;
          scan_idle(b);
        end
      end
      MD_NUM0, MD_NUM: begin
        if (mode == MD_NUM0 && (b == "b" || b == "o" || b == "x")) begin
          radix = (b == "b") ? RADIX_BIN : (b == "o") ? RADIX_OCT : RADIX_HEX;
          grow();
          mode = MD_NUM;
        end else begin
          mode = MD_NUM;
          if (radix_digit(b)) grow();
          else if (b == CH_DOT) mode = MD_NUMDOT;
          else close_redo(K_INT, b);
        end
      end
      MD_NUMDOT: begin
        if (radix_digit(b)) begin
          grow();
          grow();
          mode = MD_FRAC;
        end else begin
          emit_run(K_INT, ERR_NONE);
          mode = MD_IDLE;
          scan_idle(CH_DOT);
          scan_idle(b);
        end
      end
      MD_FRAC: begin
        if (radix_digit(b)) grow();
        else close_redo(K_FLOAT, b);
      end
      default: begin
        mode = MD_IDLE;
        scan_idle(b);
      end
    endcase
  endtask

  // flush the pending token, then the end token
  task automatic end_source();
    case (mode)
      MD_STRING: emit_run(K_ERROR, ERR_UNTERM);
      MD_OP:     emit_run(pending, ERR_NONE);
      MD_IDENT:  emit_ident();
      MD_NUM0, MD_NUM: emit_run(K_INT, ERR_NONE);
      MD_NUMDOT: begin
        emit_run(K_INT, ERR_NONE);
        mode = MD_IDLE;
        scan_idle(CH_DOT);
      end
      MD_FRAC:   emit_run(K_FLOAT, ERR_NONE);
      default: ;
    endcase
    emit(K_END, ERR_NONE, line_no, col_no, 1, offs);
    clear_state();
  endtask

  task automatic predict_tokens(logic [7:0] b, logic fin);
    step_tokens.delete();
    if (b == CH_NUL) end_source();
    else begin
      scan_byte(b);
      if (fin) end_source();
    end
    if (step_tokens.size() > 0) step_tokens[$][80] = 1'b1;
    foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
  endtask

  always @(posedge clk) begin
    logic [80:0] want;
    if (rst) begin
      clear_state();
      token_queue.delete();
      fail_count <= 0;
    end else begin
      // compare before predicting, a fresh byte cannot have a token out yet
      if (m_tvalid && m_tready) begin
        if (token_queue.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected token %h last %b", m_tdata, m_tlast);
          fail_count <= fail_count + 1;
        end else begin
          want = token_queue.pop_front();
          if (want != {m_tlast, m_tdata}) begin
            if (fail_count < 10)
              $display("token mismatch: expected kind %0d err %0d line %0d col %0d len %0d off %0d last %b, got kind %0d err %0d line %0d col %0d len %0d off %0d last %b",
                want[5:0], want[7:6], want[23:8], want[39:24], want[55:40], want[79:56], want[80],
                m_tdata[5:0], m_tdata[7:6], m_tdata[23:8], m_tdata[39:24], m_tdata[55:40],
                m_tdata[79:56], m_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) predict_tokens(s_tdata, s_tlast);
    end
    outstanding <= token_queue.size();
  end

endmodule

/* bench/testbench.sv */
// top of the source tokenizer bench: source byte stimulus and verdict
module testbench
  import stok_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          outstanding;

  // idling percentages of the current phase
  int send_gap_pct  = 0;
  int recv_stall_pct = 0;

  // pending source, {last, byte}
  logic [8:0] source_bytes [$];

  string keywords [25] = '{"and", "const", "else", "f32", "f64", "false", "for", "func",
                           "i8", "i16", "i32", "i64", "if", "not", "null", "or", "return",
                           "true", "u8", "u16", "u32", "u64", "var", "while", "xor"};
  string operators [21] = '{"(", ")", "[", "]", "{", "}", ":", ";", ",", ".", "+", "-",
                            "%", "$", "**", "//", "==", "=>", ">=", "<=", "<>"};
  string singles [5] = '{"*", "/", "=", ">", "<"};
  string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string hex_chars = "0123456789abcdefABCDEFg";

  always #5 clk = ~clk;

  source_tokenizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  source_tokenizer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // receiver backpressure, redrawn every falling edge
  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) source_bytes.push_back({1'b0, s[i]});
  endtask

  task automatic add_byte(logic [7:0] b);
    source_bytes.push_back({1'b0, b});
  endtask

  // one random fragment of source text
  task automatic add_fragment();
    int n;
    string pfx;
    case ($urandom_range(13))
      0: add_text(keywords[$urandom_range(24)]);
      1: begin
        n = $urandom_range(1, 8);
        add_byte(ident_chars[$urandom_range(52)]);
        for (int i = 1; i < n; i++) add_byte(ident_chars[$urandom_range(62)]);
      end
      2: begin
        add_byte(8'("1") + 8'($urandom_range(8)));
        n = $urandom_range(4);
        for (int i = 0; i < n; i++) add_byte(8'("0") + 8'($urandom_range(9)));
      end
      3: begin
        case ($urandom_range(2))
          0: pfx = "0b";
          1: pfx = "0o";
          default: pfx = "0x";
        endcase
        add_text(pfx);
        n = $urandom_range(4);
        // digits may fall outside the radix
        for (int i = 0; i < n; i++) add_byte(hex_chars[$urandom_range(22)]);
      end
      4: begin
        add_byte(8'("0") + 8'($urandom_range(9)));
        add_byte(CH_DOT);
        if ($urandom_range(1)) add_byte(8'("0") + 8'($urandom_range(9)));
        else add_byte(ident_chars[$urandom_range(62)]);
      end
      5: begin
        add_byte(CH_QUOTE);
        n = $urandom_range(5);
        for (int i = 0; i < n; i++) add_byte(8'($urandom_range(32, 126)) | 8'h01);
        add_byte(CH_QUOTE);
      end
      6: begin
        add_byte(CH_QUOTE);
        add_text("ab\r");
        add_byte(CH_LF);
      end
      7: begin
        add_byte(CH_HASH);
        add_text(" x\"1 ");
        add_byte(8'($urandom_range(1, 255)));
        add_byte(CH_LF);
      end
      8: add_text(operators[$urandom_range(20)]);
      9: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          case ($urandom_range(3))
            0: add_byte(CH_SPACE);
            1: add_byte(CH_TAB);
            2: add_byte(CH_CR);
            default: add_byte(CH_LF);
          endcase
      end
      10: add_byte(8'($urandom_range(1, 255)));
      11: add_byte(CH_NUL);
      12: add_text(singles[$urandom_range(4)]);
      default: add_byte("0");
    endcase
    // mostly separated, sometimes glued to the next fragment
    if ($urandom_range(3) != 0) add_byte(CH_SPACE);
  endtask

  task automatic add_random(int count);
    int start;
    start = source_bytes.size();
    while (source_bytes.size() - start < count) add_fragment();
    // scatter final-byte marks
    for (int i = start; i < source_bytes.size(); i++)
      if ($urandom_range(59) == 0) source_bytes[i][8] = 1'b1;
  endtask

  // hand one request to the block, holding valid until it is taken
  task automatic send_request(logic [8:0] item);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= item[7:0];
    s_tlast  <= item[8];
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_all();
    while (source_bytes.size() > 0) send_request(source_bytes.pop_front());
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // hold off until every predicted token has been seen
  task automatic drain();
    @(posedge clk);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("source_tokenizer verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: keywords, identifiers, pair operators, number then dot, prefix alone,
    // carriage return, comment, high byte and unterminated string at end of source
    add_text("f64 i8x=>7.q \"s\"#c");
    add_byte(CH_LF);
    add_text("0x.5\r<>*");
    add_byte(8'h80);
    add_byte(8'h7F);
    add_text("\"z");
    source_bytes[$][8] = 1'b1;
    add_text("ab");
    add_byte(CH_NUL);
    send_all();
    drain();

    add_random(120);
    send_all();
    drain();

    send_gap_pct = 76;
    add_random(120);
    send_all();
    drain();

    send_gap_pct = 0;
    recv_stall_pct = 76;
    add_random(120);
    send_all();
    drain();

    send_gap_pct = 7;
    recv_stall_pct = 7;
    add_random(110);
    add_byte(CH_NUL);
    send_all();
    drain();

    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("source_tokenizer verification clean");
    else
      $display("source_tokenizer verification failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/stok_pkg.sv
hdl/stok_scan.sv
hdl/stok_queue.sv
hdl/stok_emit.sv
hdl/source_tokenizer.sv
bench/source_tokenizer_checker.sv
bench/testbench.sv
